// File: rtl/pfd_pkg.sv
// Shared types and constants of the filtered-derivative PID controller.
package pfd_pkg;

    localparam int KW        = 63;
    localparam int CFG_IDX_W = 3;
    localparam int N_TERMS   = 5;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CMUL  = 6'b000010,
        ST_CDIV  = 6'b000100,
        ST_TERM  = 6'b001000,
        ST_ROUND = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP   = 3'd0,
        REG_INTEG  = 3'd1,
        REG_DERIV  = 3'd2,
        REG_FILTER = 3'd3,
        REG_PERIOD = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic start;
        logic done;
    } t_unit_hs;

endpackage

// File: rtl/pid_filtered_derivative.sv
// Top level of the filtered-derivative PID controller.
//
// Usage: write the five gain/period registers on the cfg channel (index 0..4:
// Kp, Ki, Kd, N, Ts). After reset and after every register write the block
// recomputes its five difference-equation coefficients in a background pass,
// run through one bit-serial multiplier and one bit-serial divider; s_tready
// and cfg_ready stay low during that pass.
// Each error item on the s channel is then worked, from acceptance to the result
// in the output register, as five products k*x, each W+1 iterations of the shared
// bit-serial multiplier, then a rounding step and a saturation step. One item
// is worked on at a time.
// The result (control_out in tdata, saturated flag in tuser) waits in the
// output register while m_tready is low; the next item may be accepted
// meanwhile and finishes only once that register frees up.
// Reset clears the registers and histories and starts the coefficient pass.
module pid_filtered_derivative #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]        i_s_tdata,   // error_sample
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        o_m_tdata,   // control_out
    output logic [0:0]                             o_m_tuser,   // saturated
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [DATA_WIDTH-1:0]                  i_cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int TD_W  = ((W + 7) / 8) * 8;
    localparam int KW    = pfd_pkg::KW;
    localparam int A0_W  = W + 1;
    localparam int MB_W  = W + 1;
    localparam int PW    = KW + MB_W;
    localparam int NUM_W = (2 * W + 3 > 64) ? 2 * W + 3 : 64;
    localparam int ACC_W = W + 68;
    localparam int KDN_W = 2 * W - F;

    pfd_pkg::t_state r_state;
    logic [2:0]      r_step;
    logic            r_launch;
    logic            r_dirty;

    logic [W-1:0]     r_kp, r_ki, r_kd, r_n, r_ts;
    logic [A0_W-1:0]  r_a0;
    logic [W-1:0]     r_kits;
    logic [KDN_W-1:0] r_kdn;
    logic [NUM_W-1:0] r_b0n, r_b1n;
    logic [KW-1:0]    r_k [pfd_pkg::N_TERMS];

    logic [W-1:0]     r_u1, r_u2, r_e0, r_e1, r_e2;
    logic [ACC_W-1:0] r_acc;

    logic             r_o_valid;
    logic [W-1:0]     r_o_data;
    logic             r_o_sat;

    pfd_pkg::t_unit_hs mul_hs, div_hs;
    logic [KW-1:0]    mul_a;
    logic [MB_W-1:0]  mul_b;
    logic [PW-1:0]    prod;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] quo;
    logic [KW-1:0]    kval;

    logic [A0_W-1:0]  one;
    logic [A0_W-1:0]  a0p1;
    logic [W-1:0]     xsel;
    logic [W-1:0]     xmag;
    logic             t_neg;
    logic [ACC_W-1:0] p_ext;
    logic [ACC_W-F-W:0] hi;
    logic             fits;
    logic [W-1:0]     res;
    logic             res_sat;
    logic             in_fire, cfg_fire, out_free;

    assign one  = A0_W'(1) << F;
    assign a0p1 = r_a0 + one;

    assign in_fire  = i_s_tvalid && o_s_tready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_o_valid || i_m_tready;

    always_comb begin
        case (r_step)
            3'd0:    xsel = r_u1;
            3'd1:    xsel = r_u2;
            3'd2:    xsel = r_e0;
            3'd3:    xsel = r_e1;
            3'd4:    xsel = r_e2;
            default: xsel = '0;
        endcase
        xmag  = xsel[W-1] ? (~xsel + 1'b1) : xsel;
        t_neg = xsel[W-1] ^ ((r_step == 3'd1) || (r_step == 3'd3));

        mul_a = '0;
        mul_b = '0;
        if (r_state == pfd_pkg::ST_TERM) begin
            mul_a = r_k[r_step];
            mul_b = {1'b0, xmag};
        end else begin
            case (r_step)
                3'd0: begin
                    mul_a = KW'(r_n);
                    mul_b = MB_W'(r_ts);
                end
                3'd1: begin
                    mul_a = KW'(r_ki);
                    mul_b = MB_W'(r_ts);
                end
                3'd2: begin
                    mul_a = KW'(r_kd);
                    mul_b = MB_W'(r_n);
                end
                3'd3: begin
                    mul_a = KW'(r_a0);
                    mul_b = MB_W'(r_kp) + MB_W'(r_kits);
                end
                3'd4: begin
                    mul_a = KW'(r_kp);
                    mul_b = a0p1;
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end

        case (r_step)
            3'd0:    div_num = NUM_W'(a0p1) << F;
            3'd1:    div_num = NUM_W'(1) << (2 * F);
            3'd2:    div_num = r_b0n;
            3'd3:    div_num = r_b1n;
            3'd4:    div_num = (NUM_W'(r_kp) + NUM_W'(r_kdn)) << F;
            default: div_num = '0;
        endcase

        kval  = (|quo[NUM_W-1:KW]) ? {KW{1'b1}} : quo[KW-1:0];
        p_ext = ACC_W'(prod);

        hi      = r_acc[ACC_W-1:F+W-1];
        fits    = (&hi) || !(|hi);
        res_sat = !fits;
        if (fits) begin
            res = r_acc[F+W-1:F];
        end else if (r_acc[ACC_W-1]) begin
            res = {1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b0, {(W-1){1'b1}}};
        end
    end

    assign mul_hs.start = r_launch &&
                          (r_state == pfd_pkg::ST_CMUL || r_state == pfd_pkg::ST_TERM);
    assign div_hs.start = r_launch && (r_state == pfd_pkg::ST_CDIV);

    pfd_mul #(
        .A_W (KW),
        .B_W (MB_W)
    ) u_pfd_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_hs.start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_hs.done),
        .o_prod  (prod)
    );

    pfd_div #(
        .N_W (NUM_W),
        .D_W (A0_W)
    ) u_pfd_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_hs.start),
        .i_num   (div_num),
        .i_den   (r_a0),
        .o_done  (div_hs.done),
        .o_quo   (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pfd_pkg::ST_IDLE;
            r_step    <= '0;
            r_launch  <= 1'b0;
            r_dirty   <= 1'b1;
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_n       <= '0;
            r_ts      <= '0;
            r_u1      <= '0;
            r_u2      <= '0;
            r_e1      <= '0;
            r_e2      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            if (cfg_fire) begin
                r_dirty <= 1'b1;
                case (pfd_pkg::t_reg_idx'(i_cfg_index))
                    pfd_pkg::REG_PROP:   r_kp <= i_cfg_data;
                    pfd_pkg::REG_INTEG:  r_ki <= i_cfg_data;
                    pfd_pkg::REG_DERIV:  r_kd <= i_cfg_data;
                    pfd_pkg::REG_FILTER: r_n  <= i_cfg_data;
                    pfd_pkg::REG_PERIOD: r_ts <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                pfd_pkg::ST_IDLE: begin
                    if (r_dirty) begin
                        r_state  <= pfd_pkg::ST_CMUL;
                        r_step   <= '0;
                        r_launch <= 1'b1;
                    end else if (in_fire) begin
                        r_state  <= pfd_pkg::ST_TERM;
                        r_step   <= '0;
                        r_launch <= 1'b1;
                    end
                end
                pfd_pkg::ST_CMUL: begin
                    if (mul_hs.done) begin
                        r_launch <= 1'b1;
                        if (r_step == 3'd4) begin
                            r_state <= pfd_pkg::ST_CDIV;
                            r_step  <= '0;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                pfd_pkg::ST_CDIV: begin
                    if (div_hs.done) begin
                        if (r_step == 3'd4) begin
                            r_state <= pfd_pkg::ST_IDLE;
                            r_dirty <= 1'b0;
                        end else begin
                            r_step   <= r_step + 1'b1;
                            r_launch <= 1'b1;
                        end
                    end
                end
                pfd_pkg::ST_TERM: begin
                    if (mul_hs.done) begin
                        if (r_step == 3'd4) begin
                            r_state <= pfd_pkg::ST_ROUND;
                        end else begin
                            r_step   <= r_step + 1'b1;
                            r_launch <= 1'b1;
                        end
                    end
                end
                pfd_pkg::ST_ROUND: begin
                    r_state <= pfd_pkg::ST_DONE;
                end
                pfd_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_state   <= pfd_pkg::ST_IDLE;
                        r_o_valid <= 1'b1;
                        r_u2      <= r_u1;
                        r_u1      <= res;
                        r_e2      <= r_e1;
                        r_e1      <= r_e0;
                    end
                end
                default: begin
                    r_state <= pfd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pfd_pkg::ST_IDLE && !r_dirty && in_fire) begin
            r_e0  <= i_s_tdata[W-1:0];
            r_acc <= '0;
        end
        if (r_state == pfd_pkg::ST_CMUL && mul_hs.done) begin
            case (r_step)
                3'd0: r_a0   <= A0_W'(prod[2*W-1:W]) + one;
                3'd1: r_kits <= prod[2*W-1:W];
                3'd2: r_kdn  <= prod[2*W-1:F];
                3'd3: r_b0n  <= NUM_W'(prod) + (NUM_W'(r_kdn) << F);
                3'd4: r_b1n  <= NUM_W'(prod) +
                                ((NUM_W'(r_kits) + (NUM_W'(r_kdn) << 1)) << F);
                default: ;
            endcase
        end
        if (r_state == pfd_pkg::ST_CDIV && div_hs.done) begin
            r_k[r_step] <= kval;
        end
        if (r_state == pfd_pkg::ST_TERM && mul_hs.done) begin
            r_acc <= r_acc + (t_neg ? ~p_ext : p_ext) + ACC_W'(t_neg);
        end
        if (r_state == pfd_pkg::ST_ROUND) begin
            r_acc <= r_acc + (ACC_W'(1) << (F - 1));
        end
        if (r_state == pfd_pkg::ST_DONE && out_free) begin
            r_o_data <= res;
            r_o_sat  <= res_sat;
        end
    end

    assign o_s_tready  = (r_state == pfd_pkg::ST_IDLE) && !r_dirty;
    assign o_cfg_ready = (r_state == pfd_pkg::ST_IDLE);
    assign o_m_tvalid  = r_o_valid;
    assign o_m_tdata   = TD_W'(r_o_data);
    assign o_m_tuser   = r_o_sat;

endmodule

// File: rtl/pfd_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module pfd_mul #(
    parameter int A_W = 63,
    parameter int B_W = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic                 o_done,
    output logic [A_W+B_W-1:0]   o_prod
);

    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(B_W + 1);

    logic [A_W-1:0] r_a;
    logic [P_W-1:0] r_p;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [A_W:0]   sum;

    always_comb begin
        sum = {1'b0, r_p[P_W-1:B_W]} + (r_p[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(B_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {sum, r_p[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// File: rtl/pfd_div.sv
// Restoring divider, one quotient bit per cycle.
module pfd_div #(
    parameter int N_W = 67,
    parameter int D_W = 33
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);

    localparam int C_W = $clog2(N_W + 1);

    logic [D_W-1:0] r_den;
    logic [D_W-1:0] r_rem;
    logic [N_W-1:0] r_q;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;
    logic [D_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_q[N_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(N_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_q   <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[N_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// File: rtl/pfd_checker.sv
// Port-level assertions for the filtered-derivative PID controller, with bind.
module pfd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]    o_m_tdata,
    input logic [0:0]                         o_m_tuser,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [pfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [DATA_WIDTH-1:0]              i_cfg_data
);

    localparam int W = DATA_WIDTH;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output item changed while stalled");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            (o_m_tdata[W-1:0] == {1'b0, {(W-1){1'b1}}}) ||
            (o_m_tdata[W-1:0] == {1'b1, {(W-1){1'b0}}}))
        else $error("saturated item not at a range bound");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready && !o_cfg_ready)
        else $error("block open right after taking an item");

    a_cfg_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_s_tready)
        else $error("item accepted before coefficients refreshed");

endmodule

bind pid_filtered_derivative pfd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

// File: bench/pid_filtered_derivative_tb.sv
// Self-checking testbench of the filtered-derivative PID controller.
module pid_filtered_derivative_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    localparam int F = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [pfd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;
    localparam logic [pfd_pkg::CFG_IDX_W-1:0] REG_TOP_CODE = 3'd7;
    localparam logic [63:0] COEF_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [W-1:0] control;
        logic         saturated;
    } t_ctrl_result;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [W-1:0]  i_s_tdata;
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [W-1:0]  o_m_tdata;
    logic [0:0]    o_m_tuser;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [pfd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [W-1:0]  i_cfg_data;

    logic [W-1:0] gain_reg [5];
    logic [W-1:0] u_hist1, u_hist2, e_hist1, e_hist2;
    t_ctrl_result control_q [$];
    int mismatches;
    int cycles;
    int burst_left;
    bit hold_req;

    pid_filtered_derivative dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] clip_coef(logic [127:0] q);
        return (q > {64'b0, COEF_MAX}) ? COEF_MAX : q[63:0];
    endfunction

    function automatic logic signed [127:0] weigh(logic [63:0] mag, bit neg, logic [W-1:0] x);
        logic signed [127:0] p;
        p = $signed({64'b0, mag}) * $signed({{(128-W){x[W-1]}}, x});
        return neg ? -p : p;
    endfunction

    function automatic t_ctrl_result predict_control(logic [W-1:0] err);
        logic [127:0] one, kp, ki, kd, nf, ts, nts, kits, kdn, a0;
        logic [127:0] b0n, b1n, b2n;
        logic [63:0] k1, k2, k3, k4, k5;
        logic signed [127:0] acc, r;
        t_ctrl_result res;
        one = 128'd1 << F;
        kp = 128'(gain_reg[pfd_pkg::REG_PROP]);
        ki = 128'(gain_reg[pfd_pkg::REG_INTEG]);
        kd = 128'(gain_reg[pfd_pkg::REG_DERIV]);
        nf = 128'(gain_reg[pfd_pkg::REG_FILTER]);
        ts = 128'(gain_reg[pfd_pkg::REG_PERIOD]);
        nts = (nf * ts) >> W;
        kits = (ki * ts) >> W;
        kdn = (kd * nf) >> F;
        a0 = one + nts;
        b0n = a0 * (kp + kits) + (kdn << F);
        b1n = kp * (a0 + one) + ((kits + (kdn << 1)) << F);
        b2n = (kp + kdn) << F;
        k1 = clip_coef(((a0 + one) << F) / a0);
        k2 = clip_coef((128'd1 << (2 * F)) / a0);
        k3 = clip_coef(b0n / a0);
        k4 = clip_coef(b1n / a0);
        k5 = clip_coef(b2n / a0);
        acc = weigh(k1, 1'b0, u_hist1) + weigh(k2, 1'b1, u_hist2) + weigh(k3, 1'b0, err)
            + weigh(k4, 1'b1, e_hist1) + weigh(k5, 1'b0, e_hist2);
        acc = acc + (128'sd1 <<< (F - 1));
        r = acc >>> F;
        res.saturated = 1'b1;
        if (r > 128'sh7FFF_FFFF) begin
            res.control = 32'h7FFF_FFFF;
        end else if (r < -128'sh8000_0000) begin
            res.control = 32'h8000_0000;
        end else begin
            res.control = r[W-1:0];
            res.saturated = 1'b0;
        end
        u_hist2 = u_hist1;
        u_hist1 = res.control;
        e_hist2 = e_hist1;
        e_hist1 = err;
        return res;
    endfunction

    // Receiver: stall pattern is redrawn at random each time the phase counter wraps; long hold on request.
    initial begin
        int mode;
        int hold_left;
        int phase;
        i_m_tready = 1'b0;
        mode = 0;
        hold_left = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (phase == 0) begin
                mode = $urandom_range(0, 3);
            end
            phase = (phase + 1) % 64;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else begin
                case (mode)
                    0: i_m_tready = 1'b1;
                    1: i_m_tready = 1'($urandom_range(0, 1));
                    2: i_m_tready = ($urandom_range(0, 3) == 0);
                    default: i_m_tready = (phase < 48) ? 1'b0 : 1'b1;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_ctrl_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (control_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: control %h sat %b", o_m_tdata, o_m_tuser);
            end else begin
                exp_res = control_q.pop_front();
                if (o_m_tdata !== exp_res.control || o_m_tuser[0] !== exp_res.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected control %h sat %b, got %h sat %b",
                                 exp_res.control, exp_res.saturated, o_m_tdata, o_m_tuser);
                end
            end
        end
    end

    task automatic send_error(logic [W-1:0] err);
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata = err;
        do @(posedge i_clk); while (!o_s_tready);
        control_q.push_back(predict_control(err));
        burst_left--;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        burst_left = 0;
        wait (control_q.size() == 0);
    endtask

    task automatic write_reg(logic [pfd_pkg::CFG_IDX_W-1:0] idx, logic [W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= pfd_pkg::REG_PERIOD) gain_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_gains(logic [W-1:0] kp, logic [W-1:0] ki, logic [W-1:0] kd,
                              logic [W-1:0] nf, logic [W-1:0] ts);
        wait_idle();
        write_reg(pfd_pkg::REG_PROP, kp);
        write_reg(pfd_pkg::REG_INTEG, ki);
        write_reg(pfd_pkg::REG_DERIV, kd);
        write_reg(pfd_pkg::REG_FILTER, nf);
        write_reg(pfd_pkg::REG_PERIOD, ts);
    endtask

    function automatic logic [W-1:0] rand_error();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) send_error(rand_error());
    endtask

    task automatic test_reset_gains();
        send_error(32'h0001_0000);
        send_error(32'h8000_0000);
        send_error(32'h7FFF_FFFF);
    endtask

    task automatic test_field_extremes();
        load_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h000A_0000, 32'h0100_0000);
        send_error(32'h0000_0000);
        send_error(32'h7FFF_FFFF);
        send_error(32'h8000_0000);
        send_error(32'hFFFF_FFFF);
        send_error(32'h0000_0001);
        send_error(32'h7FFF_FFFF);
        send_error(32'h7FFF_FFFF);
        send_error(32'h8000_0000);
        send_error(32'h8000_0000);
    endtask

    task automatic test_zero_filter_and_period();
        load_gains(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        repeat (4) send_error(32'h0000_1000);
        load_gains(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0010_0000, 32'h0000_0000);
        repeat (3) send_error(32'hFFFF_F000);
    endtask

    task automatic test_coef_overflow();
        load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_error(32'h0000_0001);
        send_error(32'hFFFF_FFFF);
        send_error(32'h0000_0000);
        load_gains(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_error(32'h0001_0000);
        send_error(32'h0000_0000);
    endtask

    task automatic test_unused_index();
        wait_idle();
        write_reg(REG_SPARE, 32'h1234_5678);
        write_reg(REG_TOP_CODE, 32'hFFFF_FFFF);
        send_error(32'h0003_0000);
        send_error(32'hFFFE_0000);
    endtask

    task automatic test_random_gains();
        repeat (5) begin
            load_gains($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                       $urandom_range(0, 32'h0001_0000), $urandom_range(0, 32'h0064_0000),
                       $urandom_range(0, 32'h0400_0000));
            send_random(100);
        end
        load_gains($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        send_random(60);
    endtask

    task automatic test_backpressure();
        load_gains(32'h0000_C000, 32'h0000_4000, 32'h0000_2000, 32'h0014_0000, 32'h0080_0000);
        hold_req = 1'b1;
        send_random(60);
        wait_idle();
        send_random(60);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pfd_pkg::REG_PROP;
        i_cfg_data = '0;
        hold_req = 1'b0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        foreach (gain_reg[i]) gain_reg[i] = '0;
        u_hist1 = '0;
        u_hist2 = '0;
        e_hist1 = '0;
        e_hist2 = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_gains();
        test_field_extremes();
        test_zero_filter_and_period();
        test_coef_overflow();
        test_unused_index();
        test_random_gains();
        test_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
